// ----- rtl/xmbt_pkg.sv -----
`default_nettype none

package xmbt_pkg;

  // Key width and derived sizes
  localparam int KEY_BITS  = 16;
  localparam int VALUE_W   = 16;
  localparam int MEX_W     = 16;
  localparam int ADDR_W    = KEY_BITS + 1;
  localparam int CNT_W     = KEY_BITS + 1;
  localparam int LVL_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int TREE_SIZE = 1 << ADDR_W;

  // Request codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF_RD,
    ST_LEAF_CHK,
    ST_INS_RD,
    ST_INS_WR,
    ST_Q_RD,
    ST_Q_CMP
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/xor_mex_bitwise_trie.sv -----
`default_nettype none

// Channel   | Ports                         | Handshake
// ----------+-------------------------------+------------------------------------
// request   | start, busy, cmd_i, value_i   | taken at clk edge with start & !busy
// result    | mex_valid_o, mex_o            | one-cycle strobe, cannot be stalled
//
// After reset a clearing pass zeroes all 2^(KEY_BITS+1) count entries, one per
// cycle (131072 entries at KEY_BITS = 16); busy stays high meanwhile.
// Insert: accept, leaf read and check, then read and write of one node per key
// bit; a repeated key ends after the check.
// Query: accept plus read and compare per key bit; the mex
// strobes in the cycle after the last compare. The receiver cannot stall.

module xor_mex_bitwise_trie (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  output logic                       busy,
  input  wire                        cmd_i,
  input  wire [xmbt_pkg::VALUE_W-1:0] value_i,
  output logic                       mex_valid_o,
  output logic [xmbt_pkg::MEX_W-1:0]  mex_o
);

  localparam int KB = xmbt_pkg::KEY_BITS;
  localparam int AW = xmbt_pkg::ADDR_W;
  localparam int CW = xmbt_pkg::CNT_W;
  localparam int LW = xmbt_pkg::LVL_W;

  // Sequencer state
  xmbt_pkg::state_e state_q, state_d;
  logic [AW-1:0]    node_q, node_d;    // tree node, also clear address
  logic [LW-1:0]    lvl_q, lvl_d;      // current key bit
  logic [KB-1:0]    key_q, key_d;      // latched key
  logic [KB-1:0]    mask_q, mask_d;    // accumulated XOR mask
  logic [KB-1:0]    res_q, res_d;      // mex being built
  logic             valid_q, valid_d;
  logic [xmbt_pkg::MEX_W-1:0] mex_q, mex_d;

  // Count memory: one write and one registered read per cycle
  logic [CW-1:0] counts_mem [xmbt_pkg::TREE_SIZE];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] mem_wdata, rdata_q;

  // Compare unit, used by the query walk: level count against the capacity of the subtree
  logic [CW-1:0] thresh;
  logic          sub_full;
  logic [KB-1:0] query_key;
  logic [AW-1:0] child;

  assign thresh    = CW'(1) << lvl_q;
  assign sub_full  = !(rdata_q < thresh);
  assign query_key = mask_q ^ KB'(value_i);

  assign busy        = (state_q != xmbt_pkg::ST_IDLE);
  assign mex_valid_o = valid_q;
  assign mex_o       = mex_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      counts_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= counts_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xmbt_pkg::ST_CLEAR;
      node_q  <= '0;
      lvl_q   <= '0;
      mask_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
      lvl_q   <= lvl_d;
      mask_q  <= mask_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
    mex_q <= mex_d;
  end

  always_comb begin
    state_d   = state_q;
    node_d    = node_q;
    lvl_d     = lvl_q;
    key_d     = key_q;
    mask_d    = mask_q;
    res_d     = res_q;
    valid_d   = 1'b0;
    mex_d     = mex_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = node_q;
    mem_raddr = node_q;
    mem_wdata = '0;
    child     = {node_q[AW-2:0], 1'b0};

    unique case (state_q)
      xmbt_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        node_d = node_q + AW'(1);
        if (node_q == {AW{1'b1}}) begin
          state_d = xmbt_pkg::ST_IDLE;
        end
      end
      xmbt_pkg::ST_IDLE: begin
        if (start) begin
          node_d = AW'(1);
          lvl_d  = LW'(KB - 1);
          res_d  = '0;
          if (cmd_i == xmbt_pkg::CMD_INSERT) begin
            key_d   = KB'(value_i);
            state_d = xmbt_pkg::ST_LEAF_RD;
          end else begin
            mask_d  = query_key;
            state_d = xmbt_pkg::ST_Q_RD;
          end
        end
      end
      xmbt_pkg::ST_LEAF_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {1'b1, key_q};
        state_d   = xmbt_pkg::ST_LEAF_CHK;
      end
      xmbt_pkg::ST_LEAF_CHK: begin
        // repeated key: leave the counts alone
        if (rdata_q != '0) begin
          state_d = xmbt_pkg::ST_IDLE;
        end else begin
          state_d = xmbt_pkg::ST_INS_RD;
        end
      end
      xmbt_pkg::ST_INS_RD: begin
        child     = {node_q[AW-2:0], key_q[lvl_q]};
        mem_re    = 1'b1;
        mem_raddr = child;
        node_d    = child;
        state_d   = xmbt_pkg::ST_INS_WR;
      end
      xmbt_pkg::ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q + CW'(1);
        if (lvl_q == '0) begin
          state_d = xmbt_pkg::ST_IDLE;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = xmbt_pkg::ST_INS_RD;
        end
      end
      xmbt_pkg::ST_Q_RD: begin
        // follow the mask bit first
        child     = {node_q[AW-2:0], mask_q[lvl_q]};
        mem_re    = 1'b1;
        mem_raddr = child;
        node_d    = child;
        state_d   = xmbt_pkg::ST_Q_CMP;
      end
      xmbt_pkg::ST_Q_CMP: begin
        if (sub_full) begin
          node_d        = {node_q[AW-1:1], ~node_q[0]};
          res_d[lvl_q]  = 1'b1;
        end
        if (lvl_q == '0) begin
          valid_d = 1'b1;
          mex_d   = xmbt_pkg::MEX_W'(res_d);
          state_d = xmbt_pkg::ST_IDLE;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = xmbt_pkg::ST_Q_RD;
        end
      end
      default: begin
        state_d = xmbt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mex_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mex_valid_o |-> $past(state_q == xmbt_pkg::ST_Q_CMP))
    else $error("result strobe not after last compare");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_ins_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == xmbt_pkg::ST_INS_WR && lvl_q != '0) |=> (state_q == xmbt_pkg::ST_INS_RD))
    else $error("insert walk left early");
`endif

endmodule

`default_nettype wire
